// ===== design/a2r_pkg.sv =====
// Package for the Roman numeral encoder.
// Holds the queue entry types, the numeral term table and the ASCII codes.
// No dependencies.
`default_nettype none

package a2r_pkg;

  localparam int unsigned VALUE_W   = 12;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned NUM_TERMS = 13;
  localparam int unsigned TERM_W    = 4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;
  localparam logic [TERM_W-1:0]  TERM_ONE  = 4'd12;

  localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
  localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
  localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
  localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
  localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
  localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
  localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
  localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               oor;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [VALUE_W-1:0] term_weight(input logic [TERM_W-1:0] idx);
    logic [VALUE_W-1:0] w;
    unique case (idx)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  function automatic logic [SYM_W-1:0] term_first(input logic [TERM_W-1:0] idx);
    logic [SYM_W-1:0] s;
    unique case (idx)
      4'd0:    s = SYM_M;
      4'd1:    s = SYM_C;
      4'd2:    s = SYM_D;
      4'd3:    s = SYM_C;
      4'd4:    s = SYM_C;
      4'd5:    s = SYM_X;
      4'd6:    s = SYM_L;
      4'd7:    s = SYM_X;
      4'd8:    s = SYM_X;
      4'd9:    s = SYM_I;
      4'd10:   s = SYM_V;
      4'd11:   s = SYM_I;
      default: s = SYM_I;
    endcase
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] term_second(input logic [TERM_W-1:0] idx);
    logic [SYM_W-1:0] s;
    unique case (idx)
      4'd1:    s = SYM_M;
      4'd3:    s = SYM_D;
      4'd5:    s = SYM_C;
      4'd7:    s = SYM_L;
      4'd9:    s = SYM_X;
      4'd11:   s = SYM_V;
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/a2r_front.sv =====
// Front stage of the Roman numeral encoder: registers a request and flags
// values outside the numeral range, then pushes it into the queue. Uses a2r_pkg.
`default_nettype none

module a2r_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [a2r_pkg::VALUE_W-1:0]  in_value,
  input  wire a2r_pkg::q_stat_t             q_stat,
  output a2r_pkg::q_push_t                  q_push
);

  logic              valid_r;
  logic              valid_nxt;
  a2r_pkg::q_entry_t entry_r;
  a2r_pkg::q_entry_t entry_nxt;

  assign in_stall = valid_r && q_stat.full;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (!in_stall) begin
      valid_nxt       = in_valid;
      entry_nxt.value = in_value;
      entry_nxt.oor   = (in_value == '0) || (in_value > a2r_pkg::VALUE_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign q_push.valid = valid_r && !q_stat.full;
  assign q_push.entry = entry_r;

endmodule

`default_nettype wire

// ===== design/a2r_queue.sv =====
// Short queue between the front and back stages of the Roman numeral encoder.
// A small register file with read and write pointers. Uses a2r_pkg.
`default_nettype none

module a2r_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire a2r_pkg::q_push_t  q_push,
  input  wire logic              q_pop,
  output a2r_pkg::q_entry_t      q_head,
  output a2r_pkg::q_stat_t       q_stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  a2r_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r;
  logic [PW-1:0]     rd_ptr_nxt;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_head       = mem_r[rd_ptr_r];

  assign do_push = q_push.valid && !q_stat.full;
  assign do_pop  = q_pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule

`default_nettype wire

// ===== design/a2r_back.sv =====
// Back stage of the Roman numeral encoder: takes queued requests and emits one
// numeral character per cycle into the output register unless stalled. Uses a2r_pkg.
`default_nettype none

module a2r_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire a2r_pkg::q_entry_t            q_head,
  input  wire a2r_pkg::q_stat_t             q_stat,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [a2r_pkg::SYM_W-1:0]         out_symbol,
  output logic                              out_is_last,
  output logic                              out_out_of_range
);

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [a2r_pkg::SYM_W-1:0]     out_sym_r;
  logic [a2r_pkg::SYM_W-1:0]     out_sym_nxt;
  logic                          out_last_r;
  logic                          out_last_nxt;
  logic                          out_oor_r;
  logic                          out_oor_nxt;
  logic                          busy_r;
  logic                          busy_nxt;
  logic                          pend_r;
  logic                          pend_nxt;
  logic [a2r_pkg::SYM_W-1:0]     pend_sym_r;
  logic [a2r_pkg::SYM_W-1:0]     pend_sym_nxt;
  logic [a2r_pkg::VALUE_W-1:0]   rest_r;
  logic [a2r_pkg::VALUE_W-1:0]   rest_nxt;
  logic [a2r_pkg::TERM_W-1:0]    sel;
  logic [a2r_pkg::VALUE_W-1:0]   rest_sub;
  logic [a2r_pkg::SYM_W-1:0]     sel_second;
  logic                          advance;

  // The largest term that fits the remainder is the greedy choice.
  always_comb begin
    sel = a2r_pkg::TERM_ONE;
    for (int t = a2r_pkg::NUM_TERMS - 1; t >= 0; t--) begin
      if (rest_r >= a2r_pkg::term_weight(a2r_pkg::TERM_W'(t))) begin
        sel = a2r_pkg::TERM_W'(t);
      end
    end
  end

  assign rest_sub   = rest_r - a2r_pkg::term_weight(sel);
  assign sel_second = a2r_pkg::term_second(sel);
  assign advance    = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_oor_nxt   = out_oor_r;
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    pend_sym_nxt  = pend_sym_r;
    rest_nxt      = rest_r;
    q_pop         = 1'b0;
    if (advance) begin
      priority if (busy_r && pend_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = pend_sym_r;
        out_last_nxt  = (rest_r == '0);
        out_oor_nxt   = 1'b0;
        pend_nxt      = 1'b0;
        busy_nxt      = (rest_r != '0);
      end else if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = a2r_pkg::term_first(sel);
        out_last_nxt  = (rest_sub == '0) && (sel_second == a2r_pkg::SYM_NONE);
        out_oor_nxt   = 1'b0;
        rest_nxt      = rest_sub;
        pend_nxt      = (sel_second != a2r_pkg::SYM_NONE);
        pend_sym_nxt  = sel_second;
        busy_nxt      = !((rest_sub == '0) && (sel_second == a2r_pkg::SYM_NONE));
      end else if (!q_stat.empty) begin
        q_pop = 1'b1;
        if (q_head.oor) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = a2r_pkg::SYM_NONE;
          out_last_nxt  = 1'b1;
          out_oor_nxt   = 1'b1;
        end else begin
          out_valid_nxt = 1'b0;
          rest_nxt      = q_head.value;
          busy_nxt      = 1'b1;
          pend_nxt      = 1'b0;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
    end
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_oor_r  <= out_oor_nxt;
    pend_sym_r <= pend_sym_nxt;
    rest_r     <= rest_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_sym_r;
  assign out_is_last      = out_last_r;
  assign out_out_of_range = out_oor_r;

`ifndef SYNTHESIS
  a_pend_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> busy_r)
    else $error("Second character pending while the sequencer is idle.");

  a_rest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !pend_r) |-> (rest_r != '0) && (rest_r <= a2r_pkg::VALUE_MAX))
    else $error("Sequencer active with an impossible remainder.");

  a_oor_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> out_last_r && (out_sym_r == a2r_pkg::SYM_NONE))
    else $error("Out-of-range result is not a single zero symbol.");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_pop)
    else $error("Queue popped while a numeral is still being emitted.");
`endif

endmodule

`default_nettype wire

// ===== design/arabic_to_roman_encoder_top.sv =====
// Roman numeral encoder top level: front stage, request queue and back stage.
// A request is registered in the front stage and then queued; the back stage loads a
// valid number before registering its first character, but registers an out-of-range
// result directly. Throughput: one character per cycle while out_stall is low; a new
// request enters the back stage only after the previous one's last character.
// Synchronous active-low reset clears all valid flags and the queue.
`default_nettype none

module arabic_to_roman_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [a2r_pkg::VALUE_W-1:0]  in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [a2r_pkg::SYM_W-1:0]         out_symbol,
  output logic                              out_is_last,
  output logic                              out_out_of_range
);

  a2r_pkg::q_push_t  q_push;
  a2r_pkg::q_stat_t  q_stat;
  a2r_pkg::q_entry_t q_head;
  logic              q_pop;

  a2r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  a2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  a2r_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_is_last      (out_is_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule

`default_nettype wire
